// ----- sv/rdc_pkg.sv -----
// Shared types and constants for the radix digit converter.
package rdc_pkg;

	localparam int VALUE_W = 31;
	localparam int BASE_W  = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;
	localparam int STEP_W  = $clog2(VALUE_W);

	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] CHAR_A      = CHAR_W'(8'h61);
	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

	typedef enum logic [1:0] {
		ST_DIGIT    = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_BADBASE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_START,
		CS_CHECK,
		CS_DIV,
		CS_PUSH,
		CS_POP,
		CS_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic    load;
		logic    div_init;
		logic    div_step;
		logic    push;
		logic    pop;
		logic    emit;
		status_t emit_status;
	} dp_cmd_t;

	typedef struct packed {
		logic bad_base;
		logic quot_zero;
		logic count_full;
		logic count_zero;
		logic div_last;
	} dp_stat_t;

endpackage

// ----- sv/rdc_ctrl.sv -----
// Controller state machine that sequences loading, division, stacking and digit output.
module rdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rdc_pkg::dp_stat_t stat,
	output rdc_pkg::dp_cmd_t  cmd,
	output logic              busy
);
	import rdc_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next      = state_q;
		cmd             = '0;
		cmd.emit_status = ST_DIGIT;
		busy            = 1'b1;
		case (state_q)
			CS_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load   = 1'b1;
					state_next = CS_START;
				end
			end
			CS_START: begin
				if (stat.bad_base) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_BADBASE;
					state_next      = CS_IDLE;
				end else if (stat.quot_zero) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_EMPTY;
					state_next      = CS_IDLE;
				end else begin
					state_next = CS_CHECK;
				end
			end
			CS_CHECK: begin
				if (stat.quot_zero) begin
					state_next = CS_POP;
				end else if (stat.count_full) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_OVERFLOW;
					state_next      = CS_IDLE;
				end else begin
					cmd.div_init = 1'b1;
					state_next   = CS_DIV;
				end
			end
			CS_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_next = CS_PUSH;
				end
			end
			CS_PUSH: begin
				cmd.push   = 1'b1;
				state_next = CS_CHECK;
			end
			CS_POP: begin
				cmd.pop    = 1'b1;
				state_next = CS_EMIT;
			end
			CS_EMIT: begin
				cmd.emit        = 1'b1;
				cmd.emit_status = ST_DIGIT;
				state_next      = stat.count_zero ? CS_IDLE : CS_POP;
			end
			default: begin
				state_next = CS_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/rdc_datapath.sv -----
// Datapath with the bit-serial divider, digit stack memory and result registers.
module rdc_datapath #(
	parameter int MAX_DIGITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [rdc_pkg::VALUE_W-1:0]        value,
	input  logic [rdc_pkg::BASE_W-1:0]         base,
	input  rdc_pkg::dp_cmd_t                   cmd,
	output rdc_pkg::dp_stat_t                  stat,
	output logic [rdc_pkg::CHAR_W-1:0]         digit_char,
	output rdc_pkg::status_t                   status,
	output logic                               last,
	output logic                               strobe
);
	import rdc_pkg::*;

	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int AW = $clog2(MAX_DIGITS);

	logic [VALUE_W-1:0] quot_q;
	logic [BASE_W-1:0]  base_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [CW-1:0]      count_q;
	logic [DIGIT_W-1:0] rd_q;
	logic [DIGIT_W-1:0] stack_mem [MAX_DIGITS];

	logic [BASE_W-1:0]  trial;
	logic               fits;
	logic [BASE_W-1:0]  trial_sub;
	logic [CW-1:0]      count_dec;

	logic [CHAR_W-1:0]  digit_char_q;
	status_t            status_q;
	logic               last_q;
	logic               strobe_q;

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] r;
		if (d < DIGIT_TEN) begin
			r = CHAR_ZERO + CHAR_W'(d);
		end else begin
			r = CHAR_A + CHAR_W'(d - DIGIT_TEN);
		end
		return r;
	endfunction

	assign trial     = {rem_q, quot_q[VALUE_W-1]};
	assign fits      = (trial >= base_q);
	assign trial_sub = trial - base_q;
	assign count_dec = count_q - CW'(1);

	assign stat.bad_base   = (base_q < BASE_MIN) || (base_q > BASE_MAX);
	assign stat.quot_zero  = (quot_q == '0);
	assign stat.count_full = (count_q == CW'(MAX_DIGITS));
	assign stat.count_zero = (count_q == '0);
	assign stat.div_last   = (step_q == STEP_W'(VALUE_W - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q <= value;
			base_q <= base;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[VALUE_W-2:0], fits};
		end
		if (cmd.div_init) begin
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= fits ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[count_q[AW-1:0]] <= rem_q;
		end
		if (cmd.pop) begin
			rd_q <= stack_mem[count_dec[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= '0;
			end else if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_dec;
			end
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.emit_status;
			if (cmd.emit_status == ST_DIGIT) begin
				digit_char_q <= to_ascii(rd_q);
				last_q       <= stat.count_zero;
			end else begin
				digit_char_q <= '0;
				last_q       <= 1'b1;
			end
		end
	end

	assign digit_char = digit_char_q;
	assign status     = status_q;
	assign last       = last_q;
	assign strobe     = strobe_q;

endmodule

// ----- sv/radix_digit_converter_unit.sv -----
// Top level of the radix digit converter: controller plus datapath.
//
//   channel   signals                          handshake
//   request   value, base                      start while busy is low
//   result    digit_char, status, last         strobe, one cycle, no back-pressure
//
// A request with n digits keeps busy high while each digit is found by a bit-serial divide
// and pushed on the stack, then popped and emitted; the divide per digit sets most of this time.
// Bad base and zero value give their single result once the controller leaves its start state.
// Reset clears the controller, the digit count and the result strobe.
// Busy stays high from acceptance until the final result is issued; results
// cannot be stalled and appear for exactly one cycle each.
module radix_digit_converter_unit #(
	parameter int MAX_DIGITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rdc_pkg::VALUE_W-1:0] value,
	input  logic [rdc_pkg::BASE_W-1:0]  base,
	output logic                        strobe,
	output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
	output rdc_pkg::status_t            status,
	output logic                        last
);
	import rdc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rdc_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.base       (base),
		.cmd        (cmd),
		.stat       (stat),
		.digit_char (digit_char),
		.status     (status),
		.last       (last),
		.strobe     (strobe)
	);

endmodule
